>>> src/binary_trie_prefix_router_defines.svh
// assertion macros for the binary trie prefix router
// no dependencies; included by the top level only
`ifndef BINARY_TRIE_PREFIX_ROUTER_DEFINES_SVH
`define BINARY_TRIE_PREFIX_ROUTER_DEFINES_SVH
`ifndef SYNTH
`define BTPR_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define BTPR_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define BTPR_ASSERT_IMP(label, ante, cons)
`define BTPR_ASSERT_NXT(label, ante, cons)
`endif
`endif

>>> src/btpr_pkg.sv
// shared types for the binary trie prefix router
// no dependencies
package btpr_pkg;
    localparam int unsigned MAX_BITS = 128;
    localparam int unsigned ADDR_W   = 128;
    localparam int unsigned LEN_W    = 8;
    localparam int unsigned ID_W     = 16;

    typedef struct packed {
        logic load;      // capture the incoming transaction
        logic rd;        // read the current node
        logic upd_res;   // lookup: take the node entry if valid
        logic step;      // move to the existing child
        logic wr_entry;  // insert: store entry on current node
        logic wr_link;   // insert: link parent to the next free node
        logic wr_clr;    // insert: clear the new node and move to it
        logic set_full;  // insert: pool exhausted
        logic emit;      // load the output register
    } t_cmd;

    typedef struct packed {
        logic is_ins;
        logic at_end;
        logic no_child;
        logic pool_out;
        logic out_free;
    } t_sts;
endpackage

>>> src/btpr_ctrl.sv
// sequencer for the trie walk
// depends on btpr_pkg
module btpr_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  btpr_pkg::t_sts  i_sts,
    output logic            o_in_ready,
    output btpr_pkg::t_cmd  o_cmd
);
    import btpr_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RD   = 3'd1;
    localparam logic [2:0] S_EV   = 3'd2;
    localparam logic [2:0] S_CLR  = 3'd3;
    localparam logic [2:0] S_DONE = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_RD;
                end
            end
            S_RD: begin
                o_cmd.rd = 1'b1;
                n_state  = S_EV;
            end
            S_EV: begin
                if (!i_sts.is_ins) begin
                    o_cmd.upd_res = 1'b1;
                    if (i_sts.at_end || i_sts.no_child) begin
                        n_state = S_DONE;
                    end else begin
                        o_cmd.step = 1'b1;
                        n_state    = S_RD;
                    end
                end else if (i_sts.at_end) begin
                    o_cmd.wr_entry = 1'b1;
                    n_state        = S_DONE;
                end else if (!i_sts.no_child) begin
                    o_cmd.step = 1'b1;
                    n_state    = S_RD;
                end else if (i_sts.pool_out) begin
                    o_cmd.set_full = 1'b1;
                    n_state        = S_DONE;
                end else begin
                    o_cmd.wr_link = 1'b1;
                    n_state       = S_CLR;
                end
            end
            S_CLR: begin
                o_cmd.wr_clr = 1'b1;
                n_state      = S_RD;
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end
endmodule

>>> src/btpr_dpath.sv
// node memory, walk registers and output register of the trie router
// depends on btpr_pkg
module btpr_dpath #(
    parameter int unsigned NODE_COUNT = 16384
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  btpr_pkg::t_cmd  i_cmd,
    output btpr_pkg::t_sts  o_sts,
    input  logic            i_req_type,
    input  logic [63:0]     i_addr_hi,
    input  logic [63:0]     i_addr_lo,
    input  logic [7:0]      i_prefix_len,
    input  logic [15:0]     i_site_id,
    input  logic            i_out_ready,
    output logic            o_out_valid,
    output logic            o_found,
    output logic [15:0]     o_site_out,
    output logic [7:0]      o_scope_len,
    output logic            o_table_full
);
    import btpr_pkg::*;

    localparam int unsigned IW = $clog2(NODE_COUNT);
    localparam int unsigned FW = $clog2(NODE_COUNT + 1);
    localparam int unsigned NW = 2 * IW + 1 + ID_W + LEN_W;
    localparam logic [FW-1:0] POOL_END = FW'(NODE_COUNT);

    typedef struct packed {
        logic [IW-1:0]   c1;
        logic [IW-1:0]   c0;
        logic            valid;
        logic [ID_W-1:0] id;
        logic [LEN_W-1:0] len;
    } t_node;

    t_node mem [NODE_COUNT];

    logic              r_ins;
    logic [ADDR_W-1:0] r_addr;
    logic [LEN_W-1:0]  r_plen;
    logic [ID_W-1:0]   r_sid;
    logic [LEN_W-1:0]  r_cnt;
    logic [IW-1:0]     r_cur;
    logic [FW-1:0]     r_free;
    logic              r_root_ok;
    t_node             r_rdata;
    logic              r_found;
    logic [ID_W-1:0]   r_site;
    logic [LEN_W-1:0]  r_scope;
    logic              r_full;
    logic              r_ov;

    t_node         node;
    logic [IW-1:0] child;
    logic          we;
    logic [IW-1:0] waddr;
    t_node         wdata;

    assign node  = (r_cur != '0 || r_root_ok) ? r_rdata : '0;
    assign child = r_addr[ADDR_W-1] ? node.c1 : node.c0;

    always_comb begin
        we    = 1'b0;
        waddr = r_cur;
        wdata = node;
        if (i_cmd.wr_entry) begin
            we          = 1'b1;
            wdata.valid = 1'b1;
            wdata.id    = r_sid;
            wdata.len   = r_plen;
        end else if (i_cmd.wr_link) begin
            we = 1'b1;
            if (r_addr[ADDR_W-1]) begin
                wdata.c1 = r_free[IW-1:0];
            end else begin
                wdata.c0 = r_free[IW-1:0];
            end
        end else if (i_cmd.wr_clr) begin
            we    = 1'b1;
            waddr = r_free[IW-1:0];
            wdata = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (i_cmd.rd) begin
            r_rdata <= mem[r_cur];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_free    <= FW'(1);
            r_root_ok <= 1'b0;
            r_ov      <= 1'b0;
        end else begin
            if (we && waddr == '0) begin
                r_root_ok <= 1'b1;
            end
            if (i_cmd.wr_clr) begin
                r_free <= r_free + FW'(1);
            end
            if (i_cmd.emit) begin
                r_ov <= 1'b1;
            end else if (i_out_ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_ins   <= i_req_type;
            r_addr  <= {i_addr_hi, i_addr_lo};
            r_plen  <= (i_prefix_len > LEN_W'(MAX_BITS)) ? LEN_W'(MAX_BITS) : i_prefix_len;
            r_sid   <= i_site_id;
            r_cnt   <= '0;
            r_cur   <= '0;
            r_found <= 1'b0;
            r_site  <= '0;
            r_scope <= '0;
            r_full  <= 1'b0;
        end else begin
            if (i_cmd.upd_res && node.valid) begin
                r_found <= 1'b1;
                r_site  <= node.id;
                r_scope <= node.len;
            end
            if (i_cmd.wr_entry) begin
                r_found <= 1'b1;
                r_site  <= r_sid;
                r_scope <= r_plen;
            end
            if (i_cmd.set_full) begin
                r_full <= 1'b1;
            end
            if (i_cmd.step || i_cmd.wr_clr) begin
                r_cur  <= i_cmd.step ? child : r_free[IW-1:0];
                r_cnt  <= r_cnt + LEN_W'(1);
                r_addr <= {r_addr[ADDR_W-2:0], 1'b0};
            end
        end
        if (i_cmd.emit) begin
            o_found      <= r_found;
            o_site_out   <= r_site;
            o_scope_len  <= r_scope;
            o_table_full <= r_full;
        end
    end

    assign o_out_valid    = r_ov;
    assign o_sts.is_ins   = r_ins;
    assign o_sts.at_end   = (r_cnt == r_plen);
    assign o_sts.no_child = (child == '0) || ({1'b0, child} >= (IW+1)'(NODE_COUNT));
    assign o_sts.pool_out = (r_free >= POOL_END);
    assign o_sts.out_free = !r_ov || i_out_ready;
endmodule

>>> src/binary_trie_prefix_router.sv
// binary trie longest prefix match router, top level
// depends on btpr_pkg, btpr_ctrl, btpr_dpath and the assertion header
//
// usage
//   input channel: i_in_valid / o_in_ready carry one request transaction;
//   i_req_type 0 is a lookup, 1 an insert of i_site_id under the first
//   i_prefix_len bits of {i_addr_hi, i_addr_lo} (lengths above 128 act as 128)
//   output channel: o_out_valid / i_out_ready carry exactly one result per request
//   walk: a lookup reads one node per trie level walked, an insert reads each
//   existing level and links and clears each allocated node, between the load
//   and the result; the pace is set by the single port node memory with its
//   registered read (one node access per level)
//   one request is in flight at a time; o_in_ready is high only when idle
//   the result sits in an output register, so a new request is taken while
//   the previous result waits; a stalled receiver holds the finished walk
//   in its last state until the output register frees up
//   reset: root empty, next free node is 1, output empty; no memory clearing
//   pass is needed since only written nodes are ever reached through links
module binary_trie_prefix_router #(
    parameter int unsigned NODE_COUNT = 16384
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_req_type,
    input  logic [63:0] i_addr_hi,
    input  logic [63:0] i_addr_lo,
    input  logic [7:0]  i_prefix_len,
    input  logic [15:0] i_site_id,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_found,
    output logic [15:0] o_site_out,
    output logic [7:0]  o_scope_len,
    output logic        o_table_full
);
    import btpr_pkg::*;

    `include "binary_trie_prefix_router_defines.svh"

    t_cmd cmd;
    t_sts sts;

    // sequencer: walks one trie level per read
    btpr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_sts      (sts),
        .o_in_ready (o_in_ready),
        .o_cmd      (cmd)
    );

    // node memory and walk state
    btpr_dpath #(
        .NODE_COUNT (NODE_COUNT)
    ) u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .i_req_type   (i_req_type),
        .i_addr_hi    (i_addr_hi),
        .i_addr_lo    (i_addr_lo),
        .i_prefix_len (i_prefix_len),
        .i_site_id    (i_site_id),
        .i_out_ready  (i_out_ready),
        .o_out_valid  (o_out_valid),
        .o_found      (o_found),
        .o_site_out   (o_site_out),
        .o_scope_len  (o_scope_len),
        .o_table_full (o_table_full)
    );

    // a full pool never reports a match
    `BTPR_ASSERT_IMP(a_full_no_found, o_out_valid && o_table_full, !o_found && o_site_out == 16'd0 && o_scope_len == 8'd0)
    // stored lengths never exceed the address width
    `BTPR_ASSERT_IMP(a_scope_range, o_out_valid, o_scope_len <= 8'd128)
    // an accepted request makes the block busy
    `BTPR_ASSERT_NXT(a_busy_after_accept, i_in_valid && o_in_ready, !o_in_ready)
    // no result is loaded while the old one is still waiting
    `BTPR_ASSERT_NXT(a_out_holds, o_out_valid && !i_out_ready, o_out_valid)
endmodule
